/* sv/dtiu_pkg.sv */
// Shared types and constants for the DUART counter/timer and interrupt unit.
// No dependencies; the top level, timer and control files import this package.
package dtiu_pkg;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// Counter/timer operating mode.
	typedef enum logic [1:0] {
		TM_OFF   = 2'd0,
		TM_ONCE  = 2'd1,
		TM_PULSE = 2'd2
	} tmode_t;

	// Register indexes.
	localparam logic [3:0] REG_ACR     = 4'd4;
	localparam logic [3:0] REG_ISR_IMR = 4'd5;
	localparam logic [3:0] REG_CTU     = 4'd6;
	localparam logic [3:0] REG_CTL     = 4'd7;
	localparam logic [3:0] REG_IVR     = 4'd12;
	localparam logic [3:0] REG_IPORT   = 4'd14;
	localparam logic [3:0] REG_STOP    = 4'd15;

	// Mode field codes of the auxiliary control register.
	localparam logic [2:0] ACR_MODE_ONCE  = 3'd3;
	localparam logic [2:0] ACR_MODE_PULSE = 3'd6;

	// Fixed read values.
	localparam logic [7:0] RD_IPORT   = 8'h01;
	localparam logic [7:0] RD_STOP    = 8'h00;
	localparam logic [7:0] RD_DEFAULT = 8'hFF;

	// Timer interrupt bit in status and mask.
	localparam int STAT_TIMER_BIT = 3;

	// Elapsed count bound.
	localparam int          CNT_W   = 24;
	localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;

	// One input item.
	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  reg_index;
		logic [7:0]  write_data;
		logic [19:0] tick_cycles;
	} item_t;

	// Values of one result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_line;
		logic [7:0] irq_vector;
	} result_t;

endpackage

/* sv/duart_timer_interrupt_unit_core.sv */
// Top level of the DUART counter/timer and interrupt unit.
// Depends on dtiu_pkg, dtiu_timer and dtiu_ctrl.
//
// Usage:
// The input channel (item_valid / item_stall) takes one item per cycle
// while item_stall is low: a register read, a register write or a tick of
// elapsed cpu cycles. Every item gives exactly one result item on the
// output channel (result_valid / result_stall) with the read byte, the
// interrupt line level after the item and the interrupt vector.
// An accepted item lands in the input register; when the output register
// is empty or its result is being taken, the item is processed and its
// result is loaded into the output register, which drives result_valid.
// Throughput is one item per cycle while the receiver does not stall, set
// by the single pass of logic between the input register and
// the output register, which also updates all timer and interrupt state.
// When the receiver stalls, the result holds in the output register and
// one more item can wait in the input register; only then is item_stall
// raised. Reset clears the control and state registers: timer off, mask,
// status, vector, counter and interrupt line zero, both channels empty.
module duart_timer_interrupt_unit_core
	import dtiu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [19:0] tick_cycles,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  read_data,
	output logic        irq_line,
	output logic [7:0]  irq_vector
);

	item_t       item_s1;
	logic        valid_s1;
	logic        out_valid_q;
	result_t     result_q;
	result_t     result;
	logic        advance, fire, accept, timeout;
	logic [15:0] counter;

	// Handshake control.
	assign advance    = !out_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{command: command, reg_index: reg_index,
				write_data: write_data, tick_cycles: tick_cycles};
		end
	end

	// Timer and register file.
	dtiu_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.counter (counter),
		.timeout (timeout)
	);

	dtiu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.timeout (timeout),
		.counter (counter),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign result_valid = out_valid_q;
	assign read_data    = result_q.read_data;
	assign irq_line     = result_q.irq_line;
	assign irq_vector   = result_q.irq_vector;

endmodule

/* sv/dtiu_timer.sv */
// Counter/timer: one-shot and periodic timeout tracking.
// Depends on dtiu_pkg.
module dtiu_timer
	import dtiu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [15:0] counter,
	output logic        timeout
);

	tmode_t            mode_q, mode_d;
	logic [CNT_W-1:0]  elapsed_q, period_q;
	logic [CNT_W:0]    sum;
	logic [CNT_W-1:0]  sat;
	logic              hit, is_tick, arm_once, arm_pulse;

	// Saturating add of the elapsed cycles and the compare with the period.
	assign sum = {1'b0, elapsed_q} + {5'd0, item.tick_cycles};
	assign sat = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	assign hit = (sat >= period_q);

	// Decode of the item.
	assign is_tick   = (item.command == CMD_TICK);
	assign arm_once  = (item.command == CMD_WRITE) && (item.reg_index == REG_ACR)
		&& (item.write_data[6:4] == ACR_MODE_ONCE);
	assign arm_pulse = (item.command == CMD_WRITE) && (item.reg_index == REG_ACR)
		&& (item.write_data[6:4] == ACR_MODE_PULSE);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (arm_once) begin
			mode_d = TM_ONCE;
		end else if (arm_pulse) begin
			mode_d = TM_PULSE;
		end else if (is_tick && (mode_q == TM_ONCE) && hit) begin
			mode_d = TM_OFF;
		end
	end

	// Timeout output: a tick in an armed mode that reaches the period.
	always_comb begin
		case (mode_q)
			TM_ONCE, TM_PULSE: timeout = is_tick && hit;
			default:           timeout = 1'b0;
		endcase
	end

	// Mode, elapsed count and period registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= TM_OFF;
			elapsed_q <= '0;
			period_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			if (arm_once) begin
				elapsed_q <= '0;
				period_q  <= {1'b0, counter, 7'd0};
			end else if (arm_pulse) begin
				elapsed_q <= '0;
				period_q  <= {5'd0, counter, 3'd0};
			end else if (is_tick && (mode_q == TM_ONCE)) begin
				elapsed_q <= sat;
			end else if (is_tick && (mode_q == TM_PULSE)) begin
				elapsed_q <= hit ? '0 : sat;
			end
		end
	end

endmodule

/* sv/dtiu_ctrl.sv */
// Register file, read decode and interrupt logic.
// Depends on dtiu_pkg.
module dtiu_ctrl
	import dtiu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic        timeout,
	output logic [15:0] counter,
	output result_t     result
);

	logic [15:0] counter_q, counter_d;
	logic [7:0]  mask_q, mask_d;
	logic [7:0]  status_q, status_d;
	logic [7:0]  vector_q, vector_d;
	logic        irq_q, irq_d;
	logic [7:0]  rd;
	logic        raise;

	assign raise   = timeout && mask_q[STAT_TIMER_BIT];
	assign counter = counter_q;

	// Next register values and read data for the item.
	always_comb begin
		counter_d = counter_q;
		mask_d    = mask_q;
		status_d  = status_q;
		vector_d  = vector_q;
		irq_d     = irq_q;
		rd        = 8'h00;
		case (item.command)
			CMD_READ: begin
				case (item.reg_index)
					REG_ISR_IMR: begin
						rd       = status_q;
						status_d = 8'h00;
					end
					REG_IPORT: rd = RD_IPORT;
					REG_STOP: begin
						rd    = RD_STOP;
						irq_d = 1'b0;
					end
					default: rd = RD_DEFAULT;
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_index)
					REG_ISR_IMR: mask_d    = item.write_data;
					REG_CTU:     counter_d = {item.write_data, counter_q[7:0]};
					REG_CTL:     counter_d = {counter_q[15:8], item.write_data};
					REG_IVR:     vector_d  = item.write_data;
					default:     ;
				endcase
			end
			CMD_TICK: begin
				if (raise) begin
					irq_d                    = 1'b1;
					status_d[STAT_TIMER_BIT] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Values the result item carries: state after the item.
	assign result.read_data  = rd;
	assign result.irq_line   = irq_d;
	assign result.irq_vector = vector_d;

	// Register update when the item completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			mask_q    <= '0;
			status_q  <= '0;
			vector_q  <= '0;
			irq_q     <= 1'b0;
		end else if (fire) begin
			counter_q <= counter_d;
			mask_q    <= mask_d;
			status_q  <= status_d;
			vector_q  <= vector_d;
			irq_q     <= irq_d;
		end
	end

endmodule

/* sv/dtiu_checker.sv */
// Port-level checks of the DUART counter/timer and interrupt unit, bound to
// the top level. Depends on duart_timer_interrupt_unit_core.
module dtiu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [7:0]  read_data,
	input logic        irq_line,
	input logic [7:0]  irq_vector
);

	// A stalled result item holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(read_data)
			&& $stable(irq_line) && $stable(irq_vector))
		else $error("stalled result item changed");

	// The input side stalls only while a result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");

	// An accepted item is followed by a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> ##2 result_valid)
		else $error("no result two edges after an accepted item");

endmodule

bind duart_timer_interrupt_unit_core dtiu_checker u_dtiu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.read_data    (read_data),
	.irq_line     (irq_line),
	.irq_vector   (irq_vector)
);
